// ===== src/cdg_pkg.sv =====
`default_nettype none
package cdg_pkg;

  localparam int FRAME_WIDTH_DEF  = 300;
  localparam int FRAME_HEIGHT_DEF = 216;

  // tile geometry and border band sizes
  localparam int TILE_W   = 6;
  localparam int TILE_H   = 12;
  localparam int BAND_TOP = 12;
  localparam int BAND_LFT = 6;

  // counters must hold tile coordinates past the frame edge (up to 383)
  localparam int XC_W = 9;
  localparam int YC_W = 9;
  localparam int TA_W = 17;

  localparam logic [5:0] GFX_COMMAND = 6'h09;

  typedef enum logic [5:0] {
    INS_MEM_PRESET    = 6'd1,
    INS_BORDER_PRESET = 6'd2,
    INS_TILE          = 6'd6,
    INS_SCROLL_PRESET = 6'd20,
    INS_SCROLL_COPY   = 6'd24,
    INS_DEF_TRANS     = 6'd28,
    INS_COLORS_LOW    = 6'd30,
    INS_COLORS_HIGH   = 6'd31,
    INS_TILE_XOR      = 6'd38
  } ins_t;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CLEAR = 8'b0000_0010,
    S_FILL  = 8'b0000_0100,
    S_PAL   = 8'b0000_1000,
    S_TRD   = 8'b0001_0000,
    S_TWR   = 8'b0010_0000,
    S_PRD   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

endpackage
`default_nettype wire

// ===== src/cdg_if.sv =====
`default_nettype none
interface cdg_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [5:0]  packet_command;
  logic [5:0]  packet_instruction;
  logic [63:0] data_low;
  logic [63:0] data_high;
  logic [8:0]  pixel_x;
  logic [7:0]  pixel_y;
  modport source (output valid, cmd, packet_command, packet_instruction, data_low,
                  data_high, pixel_x, pixel_y, input ready);
  modport sink (input valid, cmd, packet_command, packet_instruction, data_low,
                data_high, pixel_x, pixel_y, output ready);
endinterface

interface cdg_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  pixel_index;
  logic [23:0] pixel_rgb;
  logic        full_redraw;
  logic        row_changed;
  logic [4:0]  tile_row;
  logic        recognized;
  modport source (output valid, pixel_index, pixel_rgb, full_redraw, row_changed,
                  tile_row, recognized, input ready);
  modport sink (input valid, pixel_index, pixel_rgb, full_redraw, row_changed,
                tile_row, recognized, output ready);
endinterface
`default_nettype wire

// ===== src/cdg_subcode_graphics_decoder_unit.sv =====
`default_nettype none
// presets sweep the frame store pixel by pixel and tile blocks write it pixel by pixel,
// since the frame store has a single write port
// throughput: one request at a time, next taken once the sequencer is back in idle
// reset: synchronous active low; afterwards a clearing pass over all 64800 entries zeroes
// the frame store, with in ready held low; the palette clears at once
module cdg_subcode_graphics_decoder_unit
  import cdg_pkg::*;
#(
  parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  cdg_in_if.sink      in_chan,
  cdg_out_if.source   out_chan
);

  localparam int DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [TA_W-1:0] LAST_ADDR  = TA_W'(DEPTH - 1);
  localparam logic [TA_W-1:0] LINE_SKIP  = TA_W'(FRAME_WIDTH - TILE_W + 1);
  localparam logic [TA_W-1:0] ROW_STRIDE = TA_W'(FRAME_WIDTH * TILE_H);
  localparam logic [XC_W-1:0] X_LAST     = XC_W'(FRAME_WIDTH - 1);
  localparam logic [XC_W-1:0] X_MAX      = XC_W'(FRAME_WIDTH);
  localparam logic [YC_W-1:0] Y_MAX      = YC_W'(FRAME_HEIGHT);
  localparam logic [YC_W-1:0] Y_BOT      = YC_W'(FRAME_HEIGHT - BAND_TOP);
  localparam logic [XC_W-1:0] X_RGT      = XC_W'(FRAME_WIDTH - BAND_LFT);

  state_t            state_r;
  logic [TA_W-1:0]   addr_r;
  logic [XC_W-1:0]   x_r;
  logic [YC_W-1:0]   y_r;
  logic [3:0]        color_r;
  logic              border_r;
  logic              xor_r;
  logic [127:0]      data_r;
  logic [2:0]        k_r;
  logic              base_r;
  logic              changed_r;
  logic [3:0]        i_r;
  logic [2:0]        j_r;
  logic              inrng_r;

  // pending result
  logic [3:0]        res_idx_r;
  logic [23:0]       res_rgb_r;
  logic              res_full_r;
  logic              res_row_r;
  logic [4:0]        res_tile_r;
  logic              res_rec_r;

  logic              out_valid_r;
  logic [3:0]        out_idx_r;
  logic [23:0]       out_rgb_r;
  logic              out_full_r;
  logic              out_rowc_r;
  logic [4:0]        out_tile_r;
  logic              out_rec_r;

  // frame store and palette
  logic [3:0]        mem [DEPTH];
  logic [3:0]        rd_r;
  logic              we;
  logic [3:0]        wdata;
  logic [11:0]       pal_r [16];
  logic [3:0]        pal_ra;
  logic [11:0]       pal_q;

  logic              accept;
  logic              in_border;
  logic              tile_in;
  logic [7:0]        tile_bits;
  logic              tile_pix;
  logic [3:0]        tile_c;
  logic [7:0]        pb0;
  logic [7:0]        pb1;
  logic [11:0]       pal_v;
  logic [4:0]        in_row;
  logic [5:0]        in_col;

  // decode of the request at the input
  state_t            acc_state;
  logic              acc_full;
  logic              acc_row;
  logic              acc_rec;
  logic [TA_W-1:0]   acc_addr;
  logic [XC_W-1:0]   acc_x;
  logic [YC_W-1:0]   acc_y;

  assign accept = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE);

  assign in_row = in_chan.data_low[20:16];
  assign in_col = in_chan.data_low[29:24];

  // border band test for the preset sweep
  assign in_border = (y_r < YC_W'(BAND_TOP)) || (y_r >= Y_BOT) ||
                     (x_r < XC_W'(BAND_LFT)) || (x_r >= X_RGT);

  // tile pixel selection: line i is byte 4+i, bit 5-j picks color1
  assign tile_in   = (x_r < X_MAX) && (y_r < Y_MAX);
  assign tile_bits = data_r[(32 + 8 * i_r) +: 8];
  assign tile_pix  = tile_bits[3'd5 - j_r];
  assign tile_c    = (tile_pix ? data_r[11:8] : data_r[3:0]) ^ (xor_r ? rd_r : 4'h0);

  // color table entry k from byte pair 2k, 2k+1
  assign pb0   = data_r[16 * k_r +: 8];
  assign pb1   = data_r[(16 * k_r + 8) +: 8];
  assign pal_v = {pb0[5:2], pb0[1:0], pb1[5:4], pb1[3:0]};

  assign pal_ra = (state_r == S_PAL) ? {base_r, k_r} : rd_r;
  assign pal_q  = pal_r[pal_ra];

  // first state, flags and start address of the request at the input
  always_comb begin
    acc_state = S_DONE;
    acc_full  = 1'b0;
    acc_row   = 1'b0;
    acc_rec   = 1'b0;
    acc_addr  = '0;
    acc_x     = '0;
    acc_y     = '0;
    if (in_chan.cmd) begin
      // pixel read: address y*width + x
      acc_addr  = TA_W'(in_chan.pixel_y) * TA_W'(FRAME_WIDTH) + TA_W'(in_chan.pixel_x);
      acc_state = S_PRD;
    end else if (in_chan.packet_command == GFX_COMMAND) begin
      unique case (in_chan.packet_instruction)
        INS_MEM_PRESET, INS_BORDER_PRESET: begin
          acc_full  = 1'b1;
          acc_rec   = 1'b1;
          acc_state = S_FILL;
        end
        INS_COLORS_LOW, INS_COLORS_HIGH: begin
          acc_rec   = 1'b1;
          acc_state = S_PAL;
        end
        INS_TILE, INS_TILE_XOR: begin
          acc_x     = XC_W'(in_col) * XC_W'(TILE_W);
          acc_y     = YC_W'(in_row) * YC_W'(TILE_H);
          acc_addr  = TA_W'(in_row) * ROW_STRIDE + TA_W'(in_col) * TA_W'(TILE_W);
          acc_row   = 1'b1;
          acc_rec   = 1'b1;
          acc_state = S_TRD;
        end
        INS_SCROLL_PRESET, INS_SCROLL_COPY, INS_DEF_TRANS: begin
          acc_full = 1'b1;
          acc_rec  = 1'b1;
        end
        default: acc_state = S_DONE;
      endcase
    end
  end

  always_comb begin
    we    = 1'b0;
    wdata = color_r;
    unique case (state_r)
      S_CLEAR: we = 1'b1;
      S_FILL:  we = !border_r || in_border;
      S_TWR: begin
        we    = tile_in;
        wdata = tile_c;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr_r[ADDR_W-1:0]] <= wdata;
    end
    rd_r <= mem[addr_r[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < 16; p++) begin
        pal_r[p] <= 12'h000;
      end
    end else if (state_r == S_PAL) begin
      pal_r[pal_ra] <= pal_v;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      addr_r      <= '0;
      x_r         <= '0;
      y_r         <= '0;
      color_r     <= 4'h0;
      border_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // the result register is reloaded in done, so it is only released elsewhere
      if (out_chan.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            data_r     <= {in_chan.data_high, in_chan.data_low};
            color_r    <= in_chan.data_low[3:0];
            res_idx_r  <= 4'h0;
            res_rgb_r  <= 24'h0;
            res_full_r <= acc_full;
            res_row_r  <= acc_row;
            res_tile_r <= acc_row ? in_row : 5'h0;
            res_rec_r  <= acc_rec;
            addr_r     <= acc_addr;
            x_r        <= acc_x;
            y_r        <= acc_y;
            k_r        <= '0;
            i_r        <= '0;
            j_r        <= '0;
            changed_r  <= 1'b0;
            border_r   <= (in_chan.packet_instruction == INS_BORDER_PRESET);
            base_r     <= (in_chan.packet_instruction == INS_COLORS_HIGH);
            xor_r      <= (in_chan.packet_instruction == INS_TILE_XOR);
            inrng_r    <= (XC_W'(in_chan.pixel_x) < X_MAX) &&
                          (YC_W'(in_chan.pixel_y) < Y_MAX);
            state_r    <= acc_state;
          end
        end
        S_CLEAR, S_FILL: begin
          // raster sweep over the whole frame, one pixel a cycle
          if (addr_r == LAST_ADDR) begin
            addr_r  <= '0;
            color_r <= 4'h0;
            state_r <= (state_r == S_CLEAR) ? S_IDLE : S_DONE;
          end else begin
            addr_r <= addr_r + 1'b1;
            if (x_r == X_LAST) begin
              x_r <= '0;
              y_r <= y_r + 1'b1;
            end else begin
              x_r <= x_r + 1'b1;
            end
          end
        end
        S_PAL: begin
          if (pal_q != pal_v) begin
            changed_r <= 1'b1;
          end
          k_r <= k_r + 1'b1;
          if (k_r == 3'd7) begin
            res_full_r <= changed_r || (pal_q != pal_v);
            state_r    <= S_DONE;
          end
        end
        S_TRD: state_r <= S_TWR;
        S_TWR: begin
          // step to the next tile pixel
          if (j_r == 3'(TILE_W - 1)) begin
            j_r    <= '0;
            x_r    <= x_r - XC_W'(TILE_W - 1);
            y_r    <= y_r + 1'b1;
            addr_r <= addr_r + LINE_SKIP;
            i_r    <= i_r + 1'b1;
            state_r <= (i_r == 4'(TILE_H - 1)) ? S_DONE : S_TRD;
          end else begin
            j_r     <= j_r + 1'b1;
            x_r     <= x_r + 1'b1;
            addr_r  <= addr_r + 1'b1;
            state_r <= S_TRD;
          end
        end
        S_PRD: begin
          // the first pass registers the memory read into rd_r; the second takes the result from rd_r
          if (i_r == 4'd1) begin
            if (inrng_r) begin
              res_idx_r <= rd_r;
              res_rgb_r <= {pal_q[11:8], pal_q[11:8], pal_q[7:4], pal_q[7:4],
                            pal_q[3:0], pal_q[3:0]};
            end
            state_r <= S_DONE;
          end
          i_r <= i_r + 1'b1;
        end
        S_DONE: begin
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r <= 1'b1;
            out_idx_r   <= res_idx_r;
            out_rgb_r   <= res_rgb_r;
            out_full_r  <= res_full_r;
            out_rowc_r  <= res_row_r;
            out_tile_r  <= res_tile_r;
            out_rec_r   <= res_rec_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.pixel_index = out_idx_r;
  assign out_chan.pixel_rgb   = out_rgb_r;
  assign out_chan.full_redraw = out_full_r;
  assign out_chan.row_changed = out_rowc_r;
  assign out_chan.tile_row    = out_tile_r;
  assign out_chan.recognized  = out_rec_r;

`ifndef NO_ASSERTIONS
  a_row_rec : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_rowc_r |-> out_rec_r) else $error("row change without recognition");
  a_pix_pkt : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_rgb_r != 24'h0) |-> !out_rec_r && !out_full_r)
    else $error("pixel color on a packet result");
  a_busy : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_chan.ready) else $error("ready while request in work");
`endif

endmodule
`default_nettype wire
